[rtl/core/phd_pkg.sv]
// Shared types, codes and reset constants for the peak-and-hold solenoid driver.
// No dependencies; imported by phd_sol_chan, solenoid_peak_hold_driver and the bench.
`timescale 1ns / 1ps

package phd_pkg;

	// Command codes carried on the action field
	typedef enum logic [3:0] {
		ACT_TICK      = 4'd0,
		ACT_START     = 4'd1,
		ACT_FIRE      = 4'd2,
		ACT_STOP      = 4'd3,
		ACT_STOP_ALL  = 4'd4,
		ACT_GARAGE    = 4'd5,
		ACT_STANDBY   = 4'd6,
		ACT_LINE      = 4'd7,
		ACT_SHIFT     = 4'd8,
		ACT_CONVERTER = 4'd9,
		ACT_LOCK      = 4'd10
	} action_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_KICK_TICKS   = 3'd0,
		CFG_CRANK_TICKS  = 3'd1,
		CFG_KICK_DUTY    = 3'd2,
		CFG_HOLD_DUTY    = 3'd3,
		CFG_GARAGE_DUTY  = 3'd4,
		CFG_CRANK_DUTY   = 3'd5,
		CFG_LOCK_ENABLE  = 3'd6,
		CFG_LOCK_ACT_HI  = 3'd7
	} cfg_reg_t;

	// Routing solenoid drive mode
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_KICK = 2'd1,
		MODE_HOLD = 2'd2
	} mode_t;

	// Per-channel command decoded from one request
	typedef struct packed {
		logic       tick;
		logic       fire;
		logic       force_off;
		logic       load_hold;
		logic [7:0] load_duty;
	} sol_cmd_t;

	localparam int NUM_SOL = 3;

	// Register reset values
	localparam logic [15:0] KICK_TICKS_RST  = 16'd60;
	localparam logic [15:0] CRANK_TICKS_RST = 16'd400;
	localparam logic [7:0]  KICK_DUTY_RST   = 8'd212;
	localparam logic [7:0]  HOLD_DUTY_RST   = 8'd85;
	localparam logic [7:0]  GARAGE_DUTY_RST = 8'd95;
	localparam logic [7:0]  CRANK_DUTY_RST  = 8'd102;

	localparam logic [15:0] CNT_MAX         = 16'hFFFF;
	localparam logic [6:0]  PCT_MAX         = 7'd100;
	localparam logic [6:0]  STBY_SHIFT_PCT  = 7'd67;
	localparam logic [6:0]  STBY_LINE_PCT   = 7'd60;
	localparam logic [7:0]  DUTY_FULL       = 8'd255;

	// pct*255/100 as one multiply by a scaled reciprocal: 255*5243, then >> 19.
	// Exact for pct in 0..100.
	localparam logic [20:0] SCALE_MUL   = 21'd1336965;
	localparam int          SCALE_SHIFT = 19;

	function automatic logic [7:0] pct_to_duty(input logic [6:0] pct);
		logic [27:0] prod;
		prod = 28'(pct) * 28'(SCALE_MUL);
		return prod[SCALE_SHIFT +: 8];
	endfunction

	function automatic logic [6:0] clamp_pct(input logic [7:0] v);
		return (v > 8'(PCT_MAX)) ? PCT_MAX : v[6:0];
	endfunction

endpackage

[rtl/core/phd_sol_chan.sv]
// One routing solenoid: mode, duty and kick timer with saturating count.
// Depends on phd_pkg.
`timescale 1ns / 1ps

module phd_sol_chan import phd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  sol_cmd_t    cmd,
	input  logic [15:0] kick_ticks,
	input  logic [7:0]  kick_duty,
	input  logic [7:0]  hold_duty,
	output mode_t       mode,
	output logic [7:0]  duty
);

	mode_t       mode_q, mode_d;
	logic [7:0]  duty_q, duty_d;
	logic [15:0] elap_q, elap_d, elap_inc;

	// Next state: fire, then kick timing, then forced off, then forced hold
	always_comb begin
		mode_d   = mode_q;
		duty_d   = duty_q;
		elap_d   = elap_q;
		elap_inc = (elap_q != CNT_MAX) ? elap_q + 16'd1 : elap_q;
		if (cmd.fire && mode_q == MODE_OFF) begin
			mode_d = MODE_KICK;
			duty_d = kick_duty;
			elap_d = '0;
		end
		if (cmd.tick && mode_q == MODE_KICK) begin
			elap_d = elap_inc;
			if (elap_inc >= kick_ticks) begin
				mode_d = MODE_HOLD;
				duty_d = hold_duty;
			end
		end
		if (cmd.force_off) begin
			mode_d = MODE_OFF;
			duty_d = '0;
		end
		if (cmd.load_hold) begin
			mode_d = MODE_HOLD;
			duty_d = cmd.load_duty;
		end
	end

	// State registers, updated once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OFF;
			duty_q <= '0;
			elap_q <= '0;
		end else if (en) begin
			mode_q <= mode_d;
			duty_q <= duty_d;
			elap_q <= elap_d;
		end
	end

	assign mode = mode_q;
	assign duty = duty_q;

	// A fire on an idle solenoid starts the kick at kick duty
	a_fire_kicks: assert property (@(posedge clk) disable iff (!arst_n)
		en && cmd.fire && mode_q == MODE_OFF && !cmd.force_off && !cmd.load_hold
		|=> mode_q == MODE_KICK && duty_q == $past(kick_duty) && elap_q == '0)
		else $error("fire on idle solenoid did not start kick");

	// Off always means zero duty
	a_off_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_OFF |-> duty_q == '0)
		else $error("solenoid off with nonzero duty");

	// Without a request the solenoid state stays put
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(mode_q) && $stable(duty_q) && $stable(elap_q))
		else $error("solenoid state changed without a request");

endmodule

[rtl/core/solenoid_peak_hold_driver.sv]
// Top level of the peak-and-hold solenoid driver: command decode, crank pulse,
// garage ownership, pressure valves, lock and result handshake. Uses phd_pkg, phd_sol_chan.
`timescale 1ns / 1ps
//
//  Port group   Handshake               Payload
//  ----------   ---------------------   ------------------------------------------
//  in           in_valid / in_stall     action, channel, level
//  out          out_valid / out_stall   sol0..2_duty, sol_modes, line/shift/clutch
//                                       duty and pct, lock_level, crank_busy
//  cfg          cfg_we                  cfg_index, cfg_wdata
//
//  Each request is decoded and applied to the state registers, which are the result
//  register, so one request per cycle is sustained unless out_stall holds a result.
//  in_stall is high only while a result waits with out_stall high.
//  Reset (arst_n low) clears all state and loads the register defaults.
//  Valve duties are formed from the stored percents by one constant multiply.

module solenoid_peak_hold_driver import phd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  action,
	input  logic [1:0]  channel,
	input  logic [7:0]  level,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  sol0_duty,
	output logic [7:0]  sol1_duty,
	output logic [7:0]  sol2_duty,
	output logic [5:0]  sol_modes,
	output logic [7:0]  line_duty,
	output logic [7:0]  shift_duty,
	output logic [7:0]  clutch_duty,
	output logic [6:0]  line_pct,
	output logic [6:0]  shift_pct,
	output logic [6:0]  clutch_pct,
	output logic        lock_level,
	output logic        crank_busy,
	// configuration writes
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] kick_ticks_q, crank_ticks_q;
	logic [7:0]  kick_duty_q, hold_duty_q, garage_duty_q, crank_duty_q;
	logic        lock_en_q, lock_hi_q;

	logic        acc;
	logic        flag;
	logic        out_valid_q;
	logic        crank_active_q, crank_active_d;
	logic [15:0] crank_elap_q, crank_elap_d, crank_inc;
	logic        crank_end;
	logic        garage_owned_q, garage_owned_d;
	logic [6:0]  line_pct_q, line_pct_d;
	logic [6:0]  shift_pct_q, shift_pct_d;
	logic [6:0]  clutch_pct_q, clutch_pct_d;
	logic        lock_q, lock_d;

	sol_cmd_t    cmd [NUM_SOL];
	mode_t       mode [NUM_SOL];
	logic [7:0]  duty [NUM_SOL];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kick_ticks_q  <= KICK_TICKS_RST;
			crank_ticks_q <= CRANK_TICKS_RST;
			kick_duty_q   <= KICK_DUTY_RST;
			hold_duty_q   <= HOLD_DUTY_RST;
			garage_duty_q <= GARAGE_DUTY_RST;
			crank_duty_q  <= CRANK_DUTY_RST;
			lock_en_q     <= 1'b0;
			lock_hi_q     <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_KICK_TICKS:  kick_ticks_q  <= cfg_wdata;
				CFG_CRANK_TICKS: crank_ticks_q <= cfg_wdata;
				CFG_KICK_DUTY:   kick_duty_q   <= cfg_wdata[7:0];
				CFG_HOLD_DUTY:   hold_duty_q   <= cfg_wdata[7:0];
				CFG_GARAGE_DUTY: garage_duty_q <= cfg_wdata[7:0];
				CFG_CRANK_DUTY:  crank_duty_q  <= cfg_wdata[7:0];
				CFG_LOCK_ENABLE: lock_en_q     <= cfg_wdata[0];
				CFG_LOCK_ACT_HI: lock_hi_q     <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Handshake: take a request unless a result is held back
	assign in_stall = out_valid_q & out_stall;
	assign acc      = in_valid & ~in_stall;
	assign flag     = level[0];

	// Crank pulse timing
	assign crank_inc = (crank_elap_q != CNT_MAX) ? crank_elap_q + 16'd1 : crank_elap_q;
	assign crank_end = (action == ACT_TICK) && crank_active_q && (crank_inc >= crank_ticks_q);

	// Per-solenoid command decode
	always_comb begin
		for (int i = 0; i < NUM_SOL; i++) begin
			cmd[i]           = '0;
			cmd[i].tick      = (action == ACT_TICK);
			cmd[i].fire      = (action == ACT_FIRE) && (channel == 2'(i));
			cmd[i].force_off = ((action == ACT_STOP) && (channel == 2'(i)))
				|| (action == ACT_STOP_ALL)
				|| ((action == ACT_START) && (i != 0));
		end
		// solenoid zero: crank pulse start and end
		cmd[0].force_off = cmd[0].force_off | crank_end;
		if (action == ACT_START) begin
			cmd[0].load_hold = 1'b1;
			cmd[0].load_duty = crank_duty_q;
		end
		// solenoid one: garage pulse
		if (action == ACT_GARAGE) begin
			if (flag) begin
				cmd[1].load_hold = (mode[1] == MODE_OFF);
				cmd[1].load_duty = garage_duty_q;
			end else begin
				cmd[1].force_off = garage_owned_q;
			end
		end
	end

	// Shared state next values
	always_comb begin
		crank_active_d = crank_active_q;
		crank_elap_d   = crank_elap_q;
		garage_owned_d = garage_owned_q;
		line_pct_d     = line_pct_q;
		shift_pct_d    = shift_pct_q;
		clutch_pct_d   = clutch_pct_q;
		lock_d         = lock_q;
		case (action)
			ACT_TICK: begin
				if (crank_active_q) begin
					crank_elap_d = crank_inc;
					if (crank_end) crank_active_d = 1'b0;
				end
			end
			ACT_START: begin
				lock_d         = ~lock_hi_q;
				line_pct_d     = '0;
				shift_pct_d    = '0;
				clutch_pct_d   = '0;
				garage_owned_d = 1'b0;
				crank_active_d = 1'b1;
				crank_elap_d   = '0;
			end
			ACT_GARAGE: begin
				if (flag) begin
					if (mode[1] == MODE_OFF) garage_owned_d = 1'b1;
				end else begin
					garage_owned_d = 1'b0;
				end
			end
			ACT_STANDBY: begin
				if (flag) begin
					shift_pct_d = STBY_SHIFT_PCT;
					line_pct_d  = STBY_LINE_PCT;
				end else begin
					shift_pct_d = PCT_MAX;
				end
			end
			ACT_LINE:      line_pct_d   = clamp_pct(level);
			ACT_SHIFT:     shift_pct_d  = clamp_pct(level);
			ACT_CONVERTER: clutch_pct_d = clamp_pct(level);
			ACT_LOCK:      lock_d       = (flag & lock_en_q) ^ ~lock_hi_q;
			default: ;
		endcase
	end

	// Shared state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q    <= 1'b0;
			crank_active_q <= 1'b0;
			crank_elap_q   <= '0;
			garage_owned_q <= 1'b0;
			line_pct_q     <= '0;
			shift_pct_q    <= '0;
			clutch_pct_q   <= '0;
			lock_q         <= 1'b0;
		end else begin
			if (acc) begin
				out_valid_q    <= 1'b1;
				crank_active_q <= crank_active_d;
				crank_elap_q   <= crank_elap_d;
				garage_owned_q <= garage_owned_d;
				line_pct_q     <= line_pct_d;
				shift_pct_q    <= shift_pct_d;
				clutch_pct_q   <= clutch_pct_d;
				lock_q         <= lock_d;
			end else if (!out_stall) begin
				out_valid_q    <= 1'b0;
			end
		end
	end

	// Routing solenoids
	for (genvar g = 0; g < NUM_SOL; g++) begin : g_sol
		phd_sol_chan u_chan (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (acc),
			.cmd        (cmd[g]),
			.kick_ticks (kick_ticks_q),
			.kick_duty  (kick_duty_q),
			.hold_duty  (hold_duty_q),
			.mode       (mode[g]),
			.duty       (duty[g])
		);
	end

	// Result fields
	assign out_valid   = out_valid_q;
	assign sol0_duty   = duty[0];
	assign sol1_duty   = duty[1];
	assign sol2_duty   = duty[2];
	assign sol_modes   = {mode[2], mode[1], mode[0]};
	assign line_duty   = DUTY_FULL - pct_to_duty(line_pct_q);
	assign shift_duty  = DUTY_FULL - pct_to_duty(shift_pct_q);
	assign clutch_duty = pct_to_duty(clutch_pct_q);
	assign line_pct    = line_pct_q;
	assign shift_pct   = shift_pct_q;
	assign clutch_pct  = clutch_pct_q;
	assign lock_level  = lock_q;
	assign crank_busy  = crank_active_q;

	// Every accepted request produces a result next cycle
	a_acc_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> out_valid_q)
		else $error("accepted request produced no result");

	// Start leaves solenoid zero holding and the crank pulse running
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		acc && action == ACT_START |=> crank_active_q && crank_elap_q == '0
		&& mode[0] == MODE_HOLD && mode[1] == MODE_OFF && mode[2] == MODE_OFF)
		else $error("start sequence state wrong");

	// Stored percents never exceed full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_pct_q <= PCT_MAX && shift_pct_q <= PCT_MAX && clutch_pct_q <= PCT_MAX)
		else $error("stored percent above 100");

	// No request, no state change
	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(line_pct_q) && $stable(shift_pct_q) && $stable(clutch_pct_q)
		&& $stable(crank_elap_q) && $stable(lock_q) && $stable(sol_modes))
		else $error("state changed without a request");

endmodule

[dv/tb_solenoid_peak_hold_driver.sv]
`timescale 1ns / 1ps
// Self-checking bench for solenoid_peak_hold_driver: a directed command table, then random
// traffic under several register settings, checked against an in-bench drive model or a hand-written row result.
// Depends on phd_pkg (codes, modes, reset values) and the driver RTL only.

module tb_solenoid_peak_hold_driver;
	import phd_pkg::*;

	// One result as the driver presents it, in port order
	typedef struct packed {
		logic [7:0] sol0_duty;
		logic [7:0] sol1_duty;
		logic [7:0] sol2_duty;
		logic [5:0] sol_modes;
		logic [7:0] line_duty;
		logic [7:0] shift_duty;
		logic [7:0] clutch_duty;
		logic [6:0] line_pct;
		logic [6:0] shift_pct;
		logic [6:0] clutch_pct;
		logic       lock_level;
		logic       crank_busy;
	} drv_res_t;

	// Directed step: command plus an optional hand-written result
	typedef struct packed {
		logic [3:0] act;
		logic [1:0] ch;
		logic [7:0] lvl;
		logic       typed;
		drv_res_t   res;
	} cmd_row_t;

	localparam logic [3:0] ACT_SPARE_LO = 4'd11;
	localparam logic [3:0] ACT_SPARE_HI = 4'd15;
	localparam int RAND_PHASES    = 8;
	localparam int RAND_PER_PHASE = 160;
	localparam int PRINT_CAP      = 40;
	localparam int NUM_STEPS      = 26;

	// Results that follow directly from reset and the percent clamp
	localparam drv_res_t RES_RESET = '{line_duty: DUTY_FULL, shift_duty: DUTY_FULL,
		default: '0};
	localparam drv_res_t RES_LINE_FULL = '{shift_duty: DUTY_FULL, line_pct: PCT_MAX,
		default: '0};
	localparam drv_res_t RES_LS_FULL = '{line_pct: PCT_MAX, shift_pct: PCT_MAX,
		default: '0};
	localparam drv_res_t RES_ALL_FULL = '{clutch_duty: DUTY_FULL, line_pct: PCT_MAX,
		shift_pct: PCT_MAX, clutch_pct: PCT_MAX, default: '0};

	localparam cmd_row_t CMD_STEPS [0:NUM_STEPS-1] = '{
		'{ACT_TICK,      2'd0, 8'd0,   1'b1, RES_RESET},     // idle after reset
		'{ACT_SPARE_HI,  2'd3, 8'hFF,  1'b1, RES_RESET},     // unused code, all bits set
		'{ACT_LINE,      2'd0, 8'hFF,  1'b1, RES_LINE_FULL}, // clamp from 255
		'{ACT_SHIFT,     2'd0, 8'd101, 1'b1, RES_LS_FULL},   // clamp from 101
		'{ACT_CONVERTER, 2'd0, 8'd100, 1'b1, RES_ALL_FULL},  // exactly full
		'{ACT_CONVERTER, 2'd1, 8'd0,   1'b0, '0},
		'{ACT_LINE,      2'd2, 8'd50,  1'b0, '0},
		'{ACT_STANDBY,   2'd0, 8'h01,  1'b0, '0},            // park/neutral profile
		'{ACT_STANDBY,   2'd0, 8'hFE,  1'b0, '0},            // drive profile, flag clear
		'{ACT_FIRE,      2'd0, 8'd0,   1'b0, '0},
		'{ACT_FIRE,      2'd3, 8'd0,   1'b0, '0},            // channel three ignored
		'{ACT_FIRE,      2'd1, 8'd0,   1'b0, '0},
		'{ACT_FIRE,      2'd1, 8'd0,   1'b0, '0},            // already kicking: no restart
		'{ACT_TICK,      2'd0, 8'd0,   1'b0, '0},
		'{ACT_STOP,      2'd3, 8'd0,   1'b0, '0},            // channel three ignored
		'{ACT_STOP,      2'd1, 8'd0,   1'b0, '0},
		'{ACT_GARAGE,    2'd0, 8'd1,   1'b0, '0},            // take solenoid one
		'{ACT_GARAGE,    2'd0, 8'd0,   1'b0, '0},            // release it
		'{ACT_GARAGE,    2'd0, 8'd0,   1'b0, '0},            // release while not owned
		'{ACT_FIRE,      2'd1, 8'd0,   1'b0, '0},
		'{ACT_GARAGE,    2'd0, 8'd1,   1'b0, '0},            // solenoid busy: no takeover
		'{ACT_LOCK,      2'd0, 8'd1,   1'b0, '0},            // lock disabled at reset
		'{ACT_START,     2'd0, 8'd0,   1'b0, '0},
		'{ACT_STOP_ALL,  2'd0, 8'd0,   1'b0, '0},
		'{ACT_SPARE_LO,  2'd0, 8'd0,   1'b0, '0},
		'{ACT_TICK,      2'd0, 8'd0,   1'b0, '0}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  action;
	logic [1:0]  channel;
	logic [7:0]  level;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  sol0_duty, sol1_duty, sol2_duty;
	logic [5:0]  sol_modes;
	logic [7:0]  line_duty, shift_duty, clutch_duty;
	logic [6:0]  line_pct, shift_pct, clutch_pct;
	logic        lock_level;
	logic        crank_busy;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_wdata;

	solenoid_peak_hold_driver dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.action(action), .channel(channel), .level(level),
		.out_valid(out_valid), .out_stall(out_stall),
		.sol0_duty(sol0_duty), .sol1_duty(sol1_duty), .sol2_duty(sol2_duty),
		.sol_modes(sol_modes),
		.line_duty(line_duty), .shift_duty(shift_duty), .clutch_duty(clutch_duty),
		.line_pct(line_pct), .shift_pct(shift_pct), .clutch_pct(clutch_pct),
		.lock_level(lock_level), .crank_busy(crank_busy),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	// Shadow registers
	logic [15:0] kick_ticks_r  = KICK_TICKS_RST;
	logic [15:0] crank_ticks_r = CRANK_TICKS_RST;
	logic [7:0]  kick_duty_r   = KICK_DUTY_RST;
	logic [7:0]  hold_duty_r   = HOLD_DUTY_RST;
	logic [7:0]  garage_duty_r = GARAGE_DUTY_RST;
	logic [7:0]  crank_duty_r  = CRANK_DUTY_RST;
	logic        lock_en_r     = 1'b0;
	logic        lock_hi_r     = 1'b1;

	// Model state, reset values
	mode_t       sol_mode [NUM_SOL] = '{MODE_OFF, MODE_OFF, MODE_OFF};
	logic [7:0]  sol_duty [NUM_SOL] = '{8'd0, 8'd0, 8'd0};
	logic [15:0] kick_cnt [NUM_SOL] = '{16'd0, 16'd0, 16'd0};
	logic        crank_on   = 1'b0;
	logic [15:0] crank_cnt  = 16'd0;
	logic        garage_own = 1'b0;
	logic [6:0]  line_p = 7'd0, shift_p = 7'd0, clutch_p = 7'd0;
	logic        lock_pin = 1'b0;

	drv_res_t    pending_drive_q [$];
	logic        row_typed = 1'b0;
	drv_res_t    row_res = '0;
	int unsigned err_cnt = 0;
	int unsigned n_checked = 0;
	int unsigned n_sent = 0;
	int unsigned n_settings = 1;
	int unsigned burst_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_pct = 0;

	// Apply one command to the model state and return the resulting outputs
	function automatic drv_res_t predict_drive(input logic [3:0] act, input logic [1:0] ch,
			input logic [7:0] lvl);
		drv_res_t r;
		logic     flag;
		logic     engaged;
		flag = lvl[0];
		case (act)
			ACT_TICK: begin
				for (int i = 0; i < NUM_SOL; i++) begin
					if (sol_mode[i] == MODE_KICK) begin
						if (kick_cnt[i] != CNT_MAX) kick_cnt[i]++;
						if (kick_cnt[i] >= kick_ticks_r) begin
							sol_duty[i] = hold_duty_r;
							sol_mode[i] = MODE_HOLD;
						end
					end
				end
				if (crank_on) begin
					if (crank_cnt != CNT_MAX) crank_cnt++;
					if (crank_cnt >= crank_ticks_r) begin
						sol_duty[0] = 8'd0;
						sol_mode[0] = MODE_OFF;
						crank_on = 1'b0;
					end
				end
			end
			ACT_START: begin
				lock_pin = ~lock_hi_r;
				line_p = 7'd0;
				shift_p = 7'd0;
				clutch_p = 7'd0;
				for (int i = 0; i < NUM_SOL; i++) begin
					sol_duty[i] = 8'd0;
					sol_mode[i] = MODE_OFF;
				end
				sol_duty[0] = crank_duty_r;
				sol_mode[0] = MODE_HOLD;
				garage_own = 1'b0;
				crank_on = 1'b1;
				crank_cnt = 16'd0;
			end
			ACT_FIRE: begin
				if (ch < NUM_SOL && sol_mode[ch] == MODE_OFF) begin
					sol_duty[ch] = kick_duty_r;
					kick_cnt[ch] = 16'd0;
					sol_mode[ch] = MODE_KICK;
				end
			end
			ACT_STOP: begin
				if (ch < NUM_SOL) begin
					sol_duty[ch] = 8'd0;
					sol_mode[ch] = MODE_OFF;
				end
			end
			ACT_STOP_ALL: begin
				for (int i = 0; i < NUM_SOL; i++) begin
					sol_duty[i] = 8'd0;
					sol_mode[i] = MODE_OFF;
				end
			end
			ACT_GARAGE: begin
				if (flag) begin
					if (sol_mode[1] == MODE_OFF) begin
						sol_duty[1] = garage_duty_r;
						sol_mode[1] = MODE_HOLD;
						garage_own = 1'b1;
					end
				end else if (garage_own) begin
					sol_duty[1] = 8'd0;
					sol_mode[1] = MODE_OFF;
					garage_own = 1'b0;
				end
			end
			ACT_STANDBY: begin
				if (flag) begin
					shift_p = STBY_SHIFT_PCT;
					line_p = STBY_LINE_PCT;
				end else begin
					shift_p = PCT_MAX;
				end
			end
			ACT_LINE:      line_p   = (lvl > 8'(PCT_MAX)) ? PCT_MAX : lvl[6:0];
			ACT_SHIFT:     shift_p  = (lvl > 8'(PCT_MAX)) ? PCT_MAX : lvl[6:0];
			ACT_CONVERTER: clutch_p = (lvl > 8'(PCT_MAX)) ? PCT_MAX : lvl[6:0];
			ACT_LOCK: begin
				engaged = flag & lock_en_r;
				lock_pin = lock_hi_r ? engaged : ~engaged;
			end
			default: ;
		endcase
		r.sol0_duty   = sol_duty[0];
		r.sol1_duty   = sol_duty[1];
		r.sol2_duty   = sol_duty[2];
		r.sol_modes   = {sol_mode[2], sol_mode[1], sol_mode[0]};
		// line and shift valves are inverted, clutch is normal logic
		r.line_duty   = DUTY_FULL - 8'((16'(line_p) * 16'd255) / 16'd100);
		r.shift_duty  = DUTY_FULL - 8'((16'(shift_p) * 16'd255) / 16'd100);
		r.clutch_duty = 8'((16'(clutch_p) * 16'd255) / 16'd100);
		r.line_pct    = line_p;
		r.shift_pct   = shift_p;
		r.clutch_pct  = clutch_p;
		r.lock_level  = lock_pin;
		r.crank_busy  = crank_on;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		if (err_cnt <= PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
				n_checked, name, got, want));
	endtask

	// Result checker and request capture, both on accepting edges
	always @(posedge clk) begin : monitor
		drv_res_t got;
		drv_res_t want;
		drv_res_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {sol0_duty, sol1_duty, sol2_duty, sol_modes, line_duty, shift_duty,
					clutch_duty, line_pct, shift_pct, clutch_pct, lock_level, crank_busy};
				if (pending_drive_q.size() == 0) begin
					report_mismatch("result with no request pending");
				end else begin
					want = pending_drive_q.pop_front();
					check_field("sol0_duty", got.sol0_duty, want.sol0_duty);
					check_field("sol1_duty", got.sol1_duty, want.sol1_duty);
					check_field("sol2_duty", got.sol2_duty, want.sol2_duty);
					check_field("sol_modes", got.sol_modes, want.sol_modes);
					check_field("line_duty", got.line_duty, want.line_duty);
					check_field("shift_duty", got.shift_duty, want.shift_duty);
					check_field("clutch_duty", got.clutch_duty, want.clutch_duty);
					check_field("line_pct", got.line_pct, want.line_pct);
					check_field("shift_pct", got.shift_pct, want.shift_pct);
					check_field("clutch_pct", got.clutch_pct, want.clutch_pct);
					check_field("lock_level", got.lock_level, want.lock_level);
					check_field("crank_busy", got.crank_busy, want.crank_busy);
					n_checked++;
				end
			end
			if (in_valid && !in_stall) begin
				pred = predict_drive(action, channel, level);
				pending_drive_q.push_back(row_typed ? row_res : pred);
			end
		end
	end

	// Receiver back-pressure: stretches of no, light or heavy stalling
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_left = $urandom_range(4, 60);
			case ($urandom_range(0, 2))
				0: stall_pct = 0;
				1: stall_pct = 30;
				default: stall_pct = 75;
			endcase
		end
		stall_left--;
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Issue one request; sender may idle between bursts of random length
	task automatic send_request(input logic [3:0] a, input logic [1:0] c, input logic [7:0] l,
			input logic typed, input drv_res_t res);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		action <= a;
		channel <= c;
		level <= l;
		row_typed = typed;
		row_res = res;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n_sent++;
	endtask

	// Weighted random command; ticks dominate so kick and crank timers expire
	task automatic pick_command(output logic [3:0] a, output logic [1:0] c,
			output logic [7:0] l);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		c = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		l = 8'($urandom_range(0, 255));
		if (roll < 44) a = ACT_TICK;
		else if (roll < 48) a = ACT_START;
		else if (roll < 63) a = ACT_FIRE;
		else if (roll < 69) a = ACT_STOP;
		else if (roll < 71) a = ACT_STOP_ALL;
		else if (roll < 79) a = ACT_GARAGE;
		else if (roll < 83) a = ACT_STANDBY;
		else if (roll < 86) a = ACT_LINE;
		else if (roll < 89) a = ACT_SHIFT;
		else if (roll < 92) a = ACT_CONVERTER;
		else if (roll < 97) a = ACT_LOCK;
		else a = 4'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		// pressure levels lean toward the clamp boundary
		if (a inside {ACT_LINE, ACT_SHIFT, ACT_CONVERTER}) begin
			case ($urandom_range(0, 4))
				0: l = 8'd0;
				1: l = 8'(PCT_MAX);
				2: l = 8'(PCT_MAX) + 8'd1;
				3: l = 8'($urandom_range(0, 100));
				default: ;
			endcase
		end
	endtask

	task automatic run_random(input int unsigned count);
		logic [3:0] a;
		logic [1:0] c;
		logic [7:0] l;
		repeat (count) begin
			pick_command(a, c, l);
			send_request(a, c, l, 1'b0, '0);
		end
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [15:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_KICK_TICKS:  kick_ticks_r  = data;
			CFG_CRANK_TICKS: crank_ticks_r = data;
			CFG_KICK_DUTY:   kick_duty_r   = data[7:0];
			CFG_HOLD_DUTY:   hold_duty_r   = data[7:0];
			CFG_GARAGE_DUTY: garage_duty_r = data[7:0];
			CFG_CRANK_DUTY:  crank_duty_r  = data[7:0];
			CFG_LOCK_ENABLE: lock_en_r     = data[0];
			CFG_LOCK_ACT_HI: lock_hi_r     = data[0];
			default: ;
		endcase
	endtask

	// Drain, then rewrite every register; upper data bits of the narrow registers are junk to exercise masking
	task automatic configure(input logic [15:0] kt, input logic [15:0] ct,
			input logic [7:0] kd, input logic [7:0] hd, input logic [7:0] gd,
			input logic [7:0] cd, input logic le, input logic lh);
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_drive_q.size() != 0) @(posedge clk);
		write_reg(CFG_KICK_TICKS, kt);
		write_reg(CFG_CRANK_TICKS, ct);
		write_reg(CFG_KICK_DUTY, {8'($urandom), kd});
		write_reg(CFG_HOLD_DUTY, {8'($urandom), hd});
		write_reg(CFG_GARAGE_DUTY, {8'($urandom), gd});
		write_reg(CFG_CRANK_DUTY, {8'($urandom), cd});
		write_reg(CFG_LOCK_ENABLE, {15'($urandom), le});
		write_reg(CFG_LOCK_ACT_HI, {15'($urandom), lh});
		@(negedge clk);
		cfg_we <= 1'b0;
		burst_left = 0;
		n_settings++;
	endtask

	// Main stimulus
	initial begin : stimulus
		logic [15:0] crank_rand;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_TICK;
		channel = 2'd0;
		level = 8'd0;
		cfg_we = 1'b0;
		cfg_index = CFG_KICK_TICKS;
		cfg_wdata = 16'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table at reset settings
		for (int i = 0; i < NUM_STEPS; i++)
			send_request(CMD_STEPS[i].act, CMD_STEPS[i].ch, CMD_STEPS[i].lvl,
				CMD_STEPS[i].typed, CMD_STEPS[i].res);
		run_random(RAND_PER_PHASE);

		// minimum, maximum, then random timings, mostly short
		for (int ph = 1; ph < RAND_PHASES; ph++) begin
			crank_rand = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(100, 600))
				: 16'($urandom_range(1, 30));
			case (ph)
				1: configure(16'd1, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b1);
				2: configure(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0);
				default: configure(16'($urandom_range(1, 6)), crank_rand, 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
			endcase
			run_random(RAND_PER_PHASE);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_drive_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d requests (%0d directed) under %0d register settings.",
			n_sent, NUM_STEPS, n_settings);
		$display("Compared %0d results field by field; %0d mismatches.", n_checked, err_cnt);
		if (err_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Run limit, far above the slowest legal run
	initial begin : watchdog
		#400000;
		$display("Timeout: %0d requests sent, %0d results pending.", n_sent,
			pending_drive_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

[solenoid_peak_hold_driver.f]
rtl/core/phd_pkg.sv
rtl/core/phd_sol_chan.sv
rtl/core/solenoid_peak_hold_driver.sv
dv/tb_solenoid_peak_hold_driver.sv
